// ===== src/skl_pkg.sv =====
package skl_pkg;

    localparam int KEY_W        = 16;
    localparam int POS_W        = 6;
    localparam int CNT_W        = 7;
    localparam int DEF_CAPACITY = 64;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_REMOVE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // Control broadcast from the sequencer to every cell of the row.
    typedef struct packed {
        logic capture;  // compare the search key against the held key
        logic use_le;   // compare flag is "held <= key" rather than "held < key"
        logic ins;      // open a gap at the boundary and drop the new key in
        logic rem;      // close the gap at the boundary from the right
    } t_cell_ctrl;

endpackage

// ===== src/skl_cell.sv =====
module skl_cell #(
    parameter int CW    = 7,
    parameter int INDEX = 0
) (
    input  logic                     i_clk,
    input  skl_pkg::t_cell_ctrl      i_ctrl,
    input  logic [CW-1:0]            i_count,
    input  logic [skl_pkg::KEY_W-1:0] i_key,
    input  logic [skl_pkg::KEY_W-1:0] i_left_key,
    input  logic [skl_pkg::KEY_W-1:0] i_right_key,
    input  logic                     i_left_flag,
    output logic [skl_pkg::KEY_W-1:0] o_key,
    output logic                     o_flag,
    output logic                     o_first,
    output logic                     o_hit
);

    logic [skl_pkg::KEY_W-1:0] r_key;
    logic                      r_flag;
    logic                      r_eq;
    logic                      w_occupied;

    assign w_occupied = (CW'(INDEX) < i_count);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_flag <= w_occupied &&
                      (i_ctrl.use_le ? (r_key <= i_key) : (r_key < i_key));
            r_eq   <= w_occupied && (r_key == i_key);
        end
        if (i_ctrl.ins) begin
            // Cells past the boundary take their left neighbor's key.
            if (!i_left_flag) begin
                r_key <= i_left_key;
            end else if (!r_flag) begin
                r_key <= i_key;
            end
        end else if (i_ctrl.rem && !r_flag) begin
            r_key <= i_right_key;
        end
    end

    assign o_key   = r_key;
    assign o_flag  = r_flag;
    assign o_first = i_left_flag && !r_flag;
    assign o_hit   = o_first && r_eq;

endmodule

// ===== src/skl_pos_enc.sv =====
module skl_pos_enc #(
    parameter int CAPACITY = 64,
    parameter int CW       = 7
) (
    input  logic [CAPACITY-1:0] i_first,
    input  logic [CAPACITY-1:0] i_hit,
    input  logic                i_all,
    output logic [CW-1:0]       o_pos,
    output logic                o_found
);

    // The flags form a thermometer, so at most one boundary bit is set and
    // the position is a plain OR of the indexes.
    always_comb begin
        o_pos = i_all ? CW'(CAPACITY) : '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (i_first[i]) begin
                o_pos = o_pos | CW'(i);
            end
        end
    end

    assign o_found = |i_hit;

endmodule

// ===== src/sorted_key_list.sv =====
// Channel  Direction  Handshake                  Payload
// in       to block   i_in_valid / o_in_ready    i_command, i_key
// out      from block o_out_valid / i_out_ready  o_status, o_found, o_position,
//                                                o_entry_count
//
// For an item, the transfer edge captures the compare flags in every cell of the
// row; the update edge shifts the row, loads the result and reopens the input.
// The result register lets a new item be taken while a result waits; the
// update edge holds off while that register is still full and not taken.
// Reset empties the list; key storage itself is not cleared.
module sorted_key_list #(
    parameter int CAPACITY = skl_pkg::DEF_CAPACITY
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_command,
    input  logic [skl_pkg::KEY_W-1:0] i_key,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [1:0]                o_status,
    output logic                      o_found,
    output logic [skl_pkg::POS_W-1:0] o_position,
    output logic [skl_pkg::CNT_W-1:0] o_entry_count
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int EXT_W = CW + skl_pkg::CNT_W;

    typedef enum logic {
        S_IDLE,
        S_UPDATE
    } t_state;

    t_state                    r_state;
    skl_pkg::t_cmd             r_cmd;
    logic [skl_pkg::KEY_W-1:0] r_key;
    logic [CW-1:0]             r_count;
    logic                      r_out_valid;
    logic [1:0]                r_status;
    logic                      r_found;
    logic [skl_pkg::POS_W-1:0] r_position;
    logic [skl_pkg::CNT_W-1:0] r_entry_count;

    skl_pkg::t_cell_ctrl       w_ctrl;
    logic                      w_accept;
    logic                      w_commit;
    logic                      w_full;
    logic [skl_pkg::KEY_W-1:0] w_bus_key;
    logic [CW-1:0]             w_pos;
    logic                      w_hit;
    logic [CW-1:0]             n_count;
    logic [1:0]                n_status;
    logic                      n_found;
    logic [EXT_W-1:0]          w_pos_ext;
    logic [EXT_W-1:0]          w_cnt_ext;

    logic [skl_pkg::KEY_W-1:0] w_cell_key [CAPACITY];
    logic [CAPACITY-1:0]       w_flag;
    logic [CAPACITY-1:0]       w_first;
    logic [CAPACITY-1:0]       w_hit_vec;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_commit   = (r_state == S_UPDATE) && (!r_out_valid || i_out_ready);
    assign w_full     = (r_count >= CW'(CAPACITY));
    assign w_bus_key  = w_accept ? i_key : r_key;

    always_comb begin
        w_ctrl.capture = w_accept;
        w_ctrl.use_le  = (skl_pkg::t_cmd'(i_command) == skl_pkg::CMD_INSERT);
        w_ctrl.ins     = w_commit && (r_cmd == skl_pkg::CMD_INSERT) && !w_full;
        w_ctrl.rem     = w_commit && (r_cmd == skl_pkg::CMD_REMOVE) && w_hit;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                      w_left_flag;
        logic [skl_pkg::KEY_W-1:0] w_left_key;
        logic [skl_pkg::KEY_W-1:0] w_right_key;

        if (g == 0) begin : g_head
            assign w_left_flag = 1'b1;
            assign w_left_key  = w_cell_key[g];
        end else begin : g_body
            assign w_left_flag = w_flag[g-1];
            assign w_left_key  = w_cell_key[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right_key = w_cell_key[g];
        end else begin : g_next
            assign w_right_key = w_cell_key[g+1];
        end

        skl_cell #(
            .CW    (CW),
            .INDEX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_count     (r_count),
            .i_key       (w_bus_key),
            .i_left_key  (w_left_key),
            .i_right_key (w_right_key),
            .i_left_flag (w_left_flag),
            .o_key       (w_cell_key[g]),
            .o_flag      (w_flag[g]),
            .o_first     (w_first[g]),
            .o_hit       (w_hit_vec[g])
        );
    end

    skl_pos_enc #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_pos_enc (
        .i_first (w_first),
        .i_hit   (w_hit_vec),
        .i_all   (w_flag[CAPACITY-1]),
        .o_pos   (w_pos),
        .o_found (w_hit)
    );

    always_comb begin
        n_count  = r_count;
        n_status = skl_pkg::ST_OK;
        n_found  = 1'b0;
        unique case (r_cmd)
            skl_pkg::CMD_CLEAR: begin
                n_count = '0;
            end
            skl_pkg::CMD_INSERT: begin
                if (w_full) begin
                    n_status = skl_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            skl_pkg::CMD_LOOKUP: begin
                n_found = w_hit;
                if (!w_hit) begin
                    n_status = skl_pkg::ST_NOT_FOUND;
                end
            end
            skl_pkg::CMD_REMOVE: begin
                n_found = w_hit;
                if (w_hit) begin
                    n_count = r_count - CW'(1);
                end else begin
                    n_status = skl_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    assign w_pos_ext = (r_cmd == skl_pkg::CMD_CLEAR) ? '0 : EXT_W'(w_pos);
    assign w_cnt_ext = EXT_W'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (w_commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (w_accept) begin
            r_cmd <= skl_pkg::t_cmd'(i_command);
            r_key <= i_key;
        end
        if (w_commit) begin
            r_status      <= n_status;
            r_found       <= n_found;
            r_position    <= w_pos_ext[skl_pkg::POS_W-1:0];
            r_entry_count <= w_cnt_ext[skl_pkg::CNT_W-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_found       = r_found;
    assign o_position    = r_position;
    assign o_entry_count = r_entry_count;

endmodule

// ===== tb/sv/sorted_key_list_checker.sv =====
`timescale 1ns / 100ps

module sorted_key_list_checker #(
    parameter int CAPACITY = skl_pkg::DEF_CAPACITY
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [1:0]                i_command,
    input  logic [skl_pkg::KEY_W-1:0] i_key,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [1:0]                i_status,
    input  logic                      i_found,
    input  logic [skl_pkg::POS_W-1:0] i_position,
    input  logic [skl_pkg::CNT_W-1:0] i_entry_count,
    output int                        o_fail_count,
    output int                        o_pending
);

    typedef struct packed {
        skl_pkg::t_status          status;
        logic                      found;
        logic [skl_pkg::POS_W-1:0] position;
        logic [skl_pkg::CNT_W-1:0] entry_count;
    } t_list_reply;

    logic [skl_pkg::KEY_W-1:0] held_keys [CAPACITY];
    int                        held_count;
    t_list_reply               reply_queue [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        held_count   = 0;
        for (int i = 0; i < CAPACITY; i++) begin
            held_keys[i] = '0;
        end
    end

    // Applies one command to the shadow list and returns the reply it should produce.
    function automatic t_list_reply apply_command(skl_pkg::t_cmd cmd,
                                                  logic [skl_pkg::KEY_W-1:0] key);
        t_list_reply r;
        int          pos;
        bit          hit;
        r   = '0;
        pos = 0;
        hit = 1'b0;
        r.status = skl_pkg::ST_OK;
        case (cmd)
            skl_pkg::CMD_CLEAR: begin
                held_count = 0;
            end
            skl_pkg::CMD_INSERT: begin
                // A new key lands after every key equal to it.
                for (int i = 0; i < held_count; i++) begin
                    if (held_keys[i] <= key) pos++;
                end
                if (held_count >= CAPACITY) begin
                    r.status = skl_pkg::ST_FULL;
                end else begin
                    for (int i = held_count; i > pos; i--) begin
                        held_keys[i] = held_keys[i-1];
                    end
                    held_keys[pos] = key;
                    held_count++;
                end
            end
            default: begin
                for (int i = 0; i < held_count; i++) begin
                    if (held_keys[i] < key) pos++;
                end
                hit = (pos < held_count) && (held_keys[pos] == key);
                if (!hit) begin
                    r.status = skl_pkg::ST_NOT_FOUND;
                end else begin
                    r.found = 1'b1;
                    if (cmd == skl_pkg::CMD_REMOVE) begin
                        held_count--;
                        for (int i = pos; i < held_count; i++) begin
                            held_keys[i] = held_keys[i+1];
                        end
                    end
                end
            end
        endcase
        r.position    = pos[skl_pkg::POS_W-1:0];
        r.entry_count = held_count[skl_pkg::CNT_W-1:0];
        return r;
    endfunction

    task automatic note_mismatch(string what, t_list_reply want);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("%0t: %s: status %0d/%0d found %0d/%0d position %0d/%0d count %0d/%0d",
                     $time, what, want.status, i_status, want.found, i_found,
                     want.position, i_position, want.entry_count, i_entry_count);
        end
    endtask

    always @(posedge i_clk) begin
        t_list_reply want;
        if (!i_rst_n) begin
            reply_queue.delete();
            held_count = 0;
        end else begin
            // The result leaving now always belongs to an earlier transfer, so pop first.
            if (i_out_valid && i_out_ready) begin
                if (reply_queue.size() == 0) begin
                    note_mismatch("result with nothing outstanding (expected/actual)", '0);
                end else begin
                    want = reply_queue.pop_front();
                    if (want.status != i_status || want.found != i_found ||
                        want.position != i_position || want.entry_count != i_entry_count) begin
                        note_mismatch("result mismatch (expected/actual)", want);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                reply_queue.push_back(apply_command(skl_pkg::t_cmd'(i_command), i_key));
            end
        end
        o_pending = reply_queue.size();
    end

endmodule

// ===== tb/sv/sorted_key_list_tb.sv =====
`timescale 1ns / 100ps

module sorted_key_list_tb;

    localparam int CAPACITY     = skl_pkg::DEF_CAPACITY;
    localparam int KEY_W        = skl_pkg::KEY_W;
    localparam int ITEM_TARGET  = 1700;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 300;
    localparam int PAUSE_AT     = 1100;
    localparam int LIMIT_CYCLES = 400000;

    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED
    } t_phase_kind;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [1:0]                i_command = skl_pkg::CMD_CLEAR;
    logic [KEY_W-1:0]          i_key = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [1:0]                o_status;
    logic                      o_found;
    logic [skl_pkg::POS_W-1:0] o_position;
    logic [skl_pkg::CNT_W-1:0] o_entry_count;

    int               fail_count;
    int               pending;
    int               sent_count = 0;
    bit               hold_done = 1'b0;
    logic [KEY_W-1:0] key_pool [16];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    sorted_key_list #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_key         (i_key),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_position    (o_position),
        .o_entry_count (o_entry_count)
    );

    sorted_key_list_checker #(
        .CAPACITY(CAPACITY)
    ) checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_key         (i_key),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_status      (o_status),
        .i_found       (o_found),
        .i_position    (o_position),
        .i_entry_count (o_entry_count),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Valid stays high across back-to-back calls; it only drops in rest_sender.
    task automatic send_item(skl_pkg::t_cmd cmd, logic [KEY_W-1:0] key);
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_command  = cmd;
        i_key      = key;
        do @(posedge i_clk); while (!o_in_ready);
        sent_count++;
    endtask

    task automatic rest_sender(int cycles);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Most keys come from a small pool so that lookups and removes hit
    // and duplicates pile up; others are the all-zero or all-one key or random.
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return key_pool[$urandom_range(0, 15)];
        if (r < 82) return $urandom_range(0, 1) ? '1 : '0;
        return KEY_W'($urandom);
    endfunction

    function automatic skl_pkg::t_cmd pick_command(t_phase_kind kind);
        int r;
        r = $urandom_range(0, 99);
        case (kind)
            PH_FILL: begin
                if (r < 85) return skl_pkg::CMD_INSERT;
                if (r < 95) return skl_pkg::CMD_LOOKUP;
                return skl_pkg::CMD_REMOVE;
            end
            PH_DRAIN: begin
                if (r < 10) return skl_pkg::CMD_INSERT;
                if (r < 30) return skl_pkg::CMD_LOOKUP;
                return skl_pkg::CMD_REMOVE;
            end
            default: begin
                if (r < 1) return skl_pkg::CMD_CLEAR;
                if (r < 41) return skl_pkg::CMD_INSERT;
                if (r < 76) return skl_pkg::CMD_LOOKUP;
                return skl_pkg::CMD_REMOVE;
            end
        endcase
    endfunction

    initial begin
        int          phase_len;
        int          burst_left;
        bit          paused;
        t_phase_kind kind;

        burst_left = 0;
        paused     = 1'b0;
        for (int i = 0; i < 16; i++) begin
            key_pool[i] = KEY_W'($urandom);
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty list first, then duplicates, the key extremes and absent keys.
        send_item(skl_pkg::CMD_CLEAR,  16'h0000);
        send_item(skl_pkg::CMD_LOOKUP, 16'h1234);
        send_item(skl_pkg::CMD_REMOVE, 16'h1234);
        send_item(skl_pkg::CMD_INSERT, 16'h8000);
        send_item(skl_pkg::CMD_INSERT, 16'h0000);
        send_item(skl_pkg::CMD_INSERT, 16'hFFFF);
        send_item(skl_pkg::CMD_INSERT, 16'h8000);
        send_item(skl_pkg::CMD_INSERT, 16'h8000);
        send_item(skl_pkg::CMD_LOOKUP, 16'h8000);
        send_item(skl_pkg::CMD_LOOKUP, 16'h7FFF);
        send_item(skl_pkg::CMD_LOOKUP, 16'hFFFF);
        send_item(skl_pkg::CMD_LOOKUP, 16'h0000);
        send_item(skl_pkg::CMD_INSERT, 16'hAAAA);
        send_item(skl_pkg::CMD_INSERT, 16'h5555);
        send_item(skl_pkg::CMD_REMOVE, 16'h8000);
        send_item(skl_pkg::CMD_REMOVE, 16'hFFFF);
        send_item(skl_pkg::CMD_REMOVE, 16'h0000);
        send_item(skl_pkg::CMD_REMOVE, 16'h1111);
        send_item(skl_pkg::CMD_LOOKUP, 16'hFFFF);
        send_item(skl_pkg::CMD_CLEAR,  16'hFFFF);
        send_item(skl_pkg::CMD_LOOKUP, 16'h8000);

        while (sent_count < ITEM_TARGET) begin
            kind      = t_phase_kind'($urandom_range(0, 2));
            phase_len = $urandom_range(40, 160);
            for (int i = 0; i < 4; i++) begin
                key_pool[$urandom_range(0, 15)] = KEY_W'($urandom);
            end
            for (int j = 0; j < phase_len && sent_count < ITEM_TARGET; j++) begin
                if (!paused && sent_count >= PAUSE_AT) begin
                    // Let the block drain completely before going on.
                    rest_sender(1);
                    wait (pending == 0);
                    paused = 1'b1;
                end
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    if ($urandom_range(0, 99) < 60) rest_sender($urandom_range(1, 6));
                end
                burst_left--;
                send_item(pick_command(kind), pick_key());
            end
        end
        rest_sender(1);

        wait (pending == 0);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // The receiver switches between four acceptance rates, and once holds
    // off long enough for the block to back up into the input channel.
    initial begin
        int ready_pct;
        int left;
        ready_pct = 100;
        left      = 0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && sent_count >= HOLD_AT) begin
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end
            if (left == 0) begin
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 50;
                    2: ready_pct = 85;
                    default: ready_pct = 15;
                endcase
                left = 64;
            end
            left--;
            i_out_ready = ($urandom_range(0, 99) < ready_pct);
        end
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

endmodule
